FILE: hdl/i2crts_pkg.sv
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared types and codes of the register-transaction sequencer: phases,
// request codes, condition sequences, status codes and stage structs.
// ----------------------------------------------------------------------------
package i2crts_pkg;

    // transaction phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_REG  = 3'd1,
        PH_SWRX = 3'd2,
        PH_TXD  = 3'd3,
        PH_RXD  = 3'd4,
        PH_TOUT = 3'd5
    } phase_t;

    // request codes
    localparam logic [2:0] REQ_BEGIN   = 3'd0;
    localparam logic [2:0] REQ_LOAD    = 3'd1;
    localparam logic [2:0] REQ_TXRDY   = 3'd2;
    localparam logic [2:0] REQ_RXBYTE  = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    // bus condition sequences
    localparam logic [2:0] COND_NONE       = 3'd0;
    localparam logic [2:0] COND_START      = 3'd1;
    localparam logic [2:0] COND_STOP       = 3'd2;
    localparam logic [2:0] COND_START_STOP = 3'd3;
    localparam logic [2:0] COND_STOP_START = 3'd4;

    // status codes
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // bus select codes
    localparam logic [1:0] SEL_PORT_A = 2'd0;
    localparam logic [1:0] SEL_PORT_B = 2'd2;

    // timeout register reset value
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // result of one item, before the store read data is merged
    typedef struct packed {
        logic       send_valid;
        logic [7:0] reg_byte;
        logic       use_tx;
        logic       use_rx;
        logic [2:0] cond_seq;
        logic       receive_dir;
        logic       bus_port;
        logic [6:0] slave_out;
        logic       done_res;
        logic [1:0] status;
    } res_t;

    // store access strobes for one item
    typedef struct packed {
        logic tx_we;
        logic tx_re;
        logic rx_we;
        logic rx_re;
        logic rx_clr;
    } mem_ctl_t;

endpackage

FILE: hdl/i2c_register_transaction_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_unit
// I2C master register-transaction sequencer: turns begin, load, transmit
// ready, byte received, tick and read items into bus actions and status.
//
//   channel   dir   handshake            content
//   s_*       in    s_valid / s_ready    one request item
//   m_*       out   m_valid / m_ready    one result item per request
//   cfg_*     in    cfg_valid/cfg_ready  timeout_ticks write (always ready)
//
// One item is accepted per cycle while s_ready is high; its result goes through
// the store read stage (registered store reads) and then the output register.
// Reset clears the sequencer state, the receive store valid bits and the timeout
// register (2000); no clearing pass, items are accepted right after reset.
// A stalled result holds in the output register while one more item waits
// in the store read stage; after that s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_unit
    import i2crts_pkg::*;
#(
    parameter int TX_DEPTH = 32,
    parameter int RX_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [6:0]  s_slave_addr,
    input  logic [7:0]  s_reg_ptr,
    input  logic [7:0]  s_wr_len,
    input  logic [7:0]  s_rd_len,
    input  logic [1:0]  s_bus_sel,
    input  logic [7:0]  s_data_byte,
    input  logic [4:0]  s_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_valid,
    output logic [7:0]  m_byte_out,
    output logic [2:0]  m_cond_seq,
    output logic        m_receive_dir,
    output logic        m_bus_port,
    output logic [6:0]  m_slave_out,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic [7:0]  m_read_data
);

    localparam int TXA = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RXA = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    logic [15:0]    timeout_reg;
    logic           acc;
    logic           p1_adv;
    logic           p1_valid_reg, p1_valid_next;
    res_t           p1_res_reg;
    logic           m_valid_reg, m_valid_next;
    res_t           res;
    mem_ctl_t       mctl;
    logic [TXA-1:0] tx_waddr, tx_raddr;
    logic [RXA-1:0] rx_waddr, rx_raddr;
    logic [7:0]     tx_rdata, rx_rdata;
    logic           m_send_valid_reg;
    logic [7:0]     m_byte_out_reg;
    logic [2:0]     m_cond_seq_reg;
    logic           m_receive_dir_reg;
    logic           m_bus_port_reg;
    logic [6:0]     m_slave_out_reg;
    logic           m_done_res_reg;
    logic [1:0]     m_status_reg;
    logic [7:0]     m_read_data_reg;

    // timeout register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    // pipeline handshake
    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign acc     = s_valid && s_ready;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (acc) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // sequencer
    i2crts_ctrl #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH),
        .TXA      (TXA),
        .RXA      (RXA)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc           (acc),
        .timeout_ticks (timeout_reg),
        .req_type      (s_req_type),
        .slave_addr    (s_slave_addr),
        .reg_ptr       (s_reg_ptr),
        .wr_len        (s_wr_len),
        .rd_len        (s_rd_len),
        .bus_sel       (s_bus_sel),
        .index         (s_index),
        .res           (res),
        .mctl          (mctl),
        .tx_waddr      (tx_waddr),
        .tx_raddr      (tx_raddr),
        .rx_waddr      (rx_waddr),
        .rx_raddr      (rx_raddr)
    );

    // transmit store
    i2crts_txbuf #(
        .DEPTH (TX_DEPTH),
        .AW    (TXA)
    ) u_txbuf (
        .aclk  (aclk),
        .we    (mctl.tx_we),
        .waddr (tx_waddr),
        .wdata (s_data_byte),
        .re    (mctl.tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // receive store
    i2crts_rxbuf #(
        .DEPTH (RX_DEPTH),
        .AW    (RXA)
    ) u_rxbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (mctl.rx_clr),
        .we      (mctl.rx_we),
        .waddr   (rx_waddr),
        .wdata   (s_data_byte),
        .re      (mctl.rx_re),
        .raddr   (rx_raddr),
        .rdata   (rx_rdata)
    );

    // store read stage
    always_ff @(posedge aclk) begin
        if (acc) begin
            p1_res_reg <= res;
        end
    end

    // output register, store data merged in
    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_send_valid_reg  <= p1_res_reg.send_valid;
            m_byte_out_reg    <= p1_res_reg.use_tx ? tx_rdata : p1_res_reg.reg_byte;
            m_cond_seq_reg    <= p1_res_reg.cond_seq;
            m_receive_dir_reg <= p1_res_reg.receive_dir;
            m_bus_port_reg    <= p1_res_reg.bus_port;
            m_slave_out_reg   <= p1_res_reg.slave_out;
            m_done_res_reg    <= p1_res_reg.done_res;
            m_status_reg      <= p1_res_reg.status;
            m_read_data_reg   <= p1_res_reg.use_rx ? rx_rdata : 8'd0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_send_valid  = m_send_valid_reg;
    assign m_byte_out    = m_byte_out_reg;
    assign m_cond_seq    = m_cond_seq_reg;
    assign m_receive_dir = m_receive_dir_reg;
    assign m_bus_port    = m_bus_port_reg;
    assign m_slave_out   = m_slave_out_reg;
    assign m_done_res    = m_done_res_reg;
    assign m_status      = m_status_reg;
    assign m_read_data   = m_read_data_reg;

endmodule

FILE: hdl/i2crts_txbuf.sv
// ----------------------------------------------------------------------------
// i2crts_txbuf
// Transmit byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module i2crts_txbuf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/i2crts_rxbuf.sv
// ----------------------------------------------------------------------------
// i2crts_rxbuf
// Receive byte store with one valid bit per entry; a clear drops all valid
// bits at once, and an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module i2crts_rxbuf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       data_reg;
    logic             hit_reg;

    // entry valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            data_reg <= mem[raddr];
            hit_reg  <= vld_reg[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : 8'd0;

endmodule

FILE: hdl/i2crts_ctrl.sv
// ----------------------------------------------------------------------------
// i2crts_ctrl
// Transaction sequencer: keeps phase, counters, positions and timer, updates
// them for each accepted item and issues the store accesses it needs.
// ----------------------------------------------------------------------------
module i2crts_ctrl
    import i2crts_pkg::*;
#(
    parameter int TX_DEPTH = 32,
    parameter int RX_DEPTH = 32,
    parameter int TXA      = 5,
    parameter int RXA      = 5
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           acc,
    input  logic [15:0]    timeout_ticks,
    input  logic [2:0]     req_type,
    input  logic [6:0]     slave_addr,
    input  logic [7:0]     reg_ptr,
    input  logic [7:0]     wr_len,
    input  logic [7:0]     rd_len,
    input  logic [1:0]     bus_sel,
    input  logic [4:0]     index,
    output res_t           res,
    output mem_ctl_t       mctl,
    output logic [TXA-1:0] tx_waddr,
    output logic [TXA-1:0] tx_raddr,
    output logic [RXA-1:0] rx_waddr,
    output logic [RXA-1:0] rx_raddr
);

    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int RCW = $clog2(RX_DEPTH + 1);
    localparam logic [8:0] TXD9 = 9'(TX_DEPTH);
    localparam logic [8:0] RXD9 = 9'(RX_DEPTH);

    phase_t         phase_reg, phase_next;
    logic [TCW-1:0] tx_left_reg, tx_left_next;
    logic [RCW-1:0] rx_left_reg, rx_left_next;
    logic [TXA-1:0] tx_pos_reg, tx_pos_next;
    logic [RXA-1:0] rx_pos_reg, rx_pos_next;
    logic [7:0]     saved_reg, saved_next;
    logic           port_reg, port_next;
    logic [15:0]    elapsed_reg, elapsed_next;
    logic           waiting_reg, waiting_next;

    logic [8:0]     idx9;
    logic [8:0]     tx_sat;
    logic [8:0]     rx_sat;
    logic [RCW-1:0] rx_left_new;

    // index and counts widened for compares against the depths
    assign idx9   = {4'd0, index};
    assign tx_sat = ({1'b0, wr_len} > TXD9) ? TXD9 : {1'b0, wr_len};
    assign rx_sat = ({1'b0, rd_len} > RXD9) ? 9'd1 : {1'b0, rd_len};

    // state registers, updated on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tx_left_reg <= '0;
            rx_left_reg <= '0;
            tx_pos_reg  <= '0;
            rx_pos_reg  <= '0;
            saved_reg   <= '0;
            port_reg    <= 1'b0;
            elapsed_reg <= '0;
            waiting_reg <= 1'b0;
        end else if (acc) begin
            phase_reg   <= phase_next;
            tx_left_reg <= tx_left_next;
            rx_left_reg <= rx_left_next;
            tx_pos_reg  <= tx_pos_next;
            rx_pos_reg  <= rx_pos_next;
            saved_reg   <= saved_next;
            port_reg    <= port_next;
            elapsed_reg <= elapsed_next;
            waiting_reg <= waiting_next;
        end
    end

    // next state, result and store accesses
    always_comb begin
        phase_next   = phase_reg;
        tx_left_next = tx_left_reg;
        rx_left_next = rx_left_reg;
        tx_pos_next  = tx_pos_reg;
        rx_pos_next  = rx_pos_reg;
        saved_next   = saved_reg;
        port_next    = port_reg;
        elapsed_next = elapsed_reg;
        waiting_next = waiting_reg;
        rx_left_new  = rx_left_reg;

        res          = '0;
        mctl         = '0;
        tx_waddr     = idx9[TXA-1:0];
        tx_raddr     = tx_pos_reg;
        rx_waddr     = rx_pos_reg;
        rx_raddr     = idx9[RXA-1:0];

        case (req_type)
            REQ_BEGIN: begin
                tx_left_next  = tx_sat[TCW-1:0];
                rx_left_next  = rx_sat[RCW-1:0];
                tx_pos_next   = '0;
                rx_pos_next   = '0;
                mctl.rx_clr   = 1'b1;
                saved_next    = reg_ptr;
                if (bus_sel == SEL_PORT_A) begin
                    port_next = 1'b0;
                end else if (bus_sel == SEL_PORT_B) begin
                    port_next = 1'b1;
                end
                phase_next    = PH_REG;
                elapsed_next  = '0;
                waiting_next  = 1'b1;
                res.cond_seq  = COND_START;
                res.slave_out = slave_addr;
            end
            REQ_LOAD: begin
                if (idx9 < TXD9) begin
                    mctl.tx_we = 1'b1;
                end
            end
            REQ_TXRDY: begin
                case (phase_reg)
                    PH_REG: begin
                        res.send_valid = 1'b1;
                        res.reg_byte   = saved_reg;
                        if (rx_left_reg != '0 && tx_left_reg == '0) begin
                            phase_next = PH_SWRX;
                        end else begin
                            phase_next = PH_TXD;
                        end
                    end
                    PH_SWRX: begin
                        phase_next      = PH_RXD;
                        res.receive_dir = 1'b1;
                        res.cond_seq    = (rx_left_reg == RCW'(1)) ? COND_START_STOP
                                                                   : COND_START;
                    end
                    PH_TXD: begin
                        if (tx_left_reg != '0) begin
                            // next data byte comes from the transmit store
                            res.send_valid = 1'b1;
                            res.use_tx     = 1'b1;
                            mctl.tx_re     = 1'b1;
                            tx_pos_next    = tx_pos_reg + TXA'(1);
                            tx_left_next   = tx_left_reg - TCW'(1);
                        end else if (rx_left_reg != '0) begin
                            res.cond_seq    = COND_STOP_START;
                            res.receive_dir = 1'b1;
                            phase_next      = PH_RXD;
                        end else begin
                            res.cond_seq = COND_STOP;
                            res.done_res = 1'b1;
                            phase_next   = PH_IDLE;
                            waiting_next = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_RXBYTE: begin
                if (phase_reg == PH_RXD) begin
                    if (rx_left_reg != '0) begin
                        mctl.rx_we  = 1'b1;
                        rx_pos_next = rx_pos_reg + RXA'(1);
                        rx_left_new = rx_left_reg - RCW'(1);
                    end
                    rx_left_next = rx_left_new;
                    if (rx_left_new == RCW'(1)) begin
                        res.cond_seq = COND_STOP;
                    end else if (rx_left_new == '0) begin
                        res.done_res = 1'b1;
                        phase_next   = PH_IDLE;
                        waiting_next = 1'b0;
                    end
                end
            end
            REQ_TICK: begin
                if (waiting_reg) begin
                    if (elapsed_reg >= timeout_ticks) begin
                        phase_next   = PH_TOUT;
                        waiting_next = 1'b0;
                        res.done_res = 1'b1;
                    end else begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
            end
            REQ_READ: begin
                if (idx9 < RXD9) begin
                    mctl.rx_re = 1'b1;
                    res.use_rx = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // qualify store strobes with acceptance
        mctl.tx_we  = mctl.tx_we  & acc;
        mctl.tx_re  = mctl.tx_re  & acc;
        mctl.rx_we  = mctl.rx_we  & acc;
        mctl.rx_re  = mctl.rx_re  & acc;
        mctl.rx_clr = mctl.rx_clr & acc;

        res.bus_port = port_next;
        case (phase_next)
            PH_IDLE: res.status = ST_IDLE;
            PH_TOUT: res.status = ST_TIMEOUT;
            default: res.status = ST_BUSY;
        endcase
    end

endmodule
